// ===== hdl/fpr_pkg.sv =====
// Shared types and constants for the framed packet receiver.
package fpr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned KIND_W    = 2;

    localparam logic [BYTE_W-1:0] START_BYTE    = 8'h7E;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd50;
    localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;
    localparam logic [BYTE_W-1:0] CMD_FIRST     = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_LAST      = 8'h04;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] data;
    } t_beat;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] arg;
    } t_event;

endpackage

// ===== hdl/fpr_in_stage.sv =====
// Input register for received bytes and ticks.
module fpr_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,  // data_byte
    input  logic          s_axis_tuser,  // operation
    input  logic          i_take,
    output logic          o_valid,
    output fpr_pkg::t_beat o_beat
);
    import fpr_pkg::*;

    logic  r_valid;
    t_beat r_beat;

    assign s_axis_tready = !r_valid || i_take;
    assign o_valid       = r_valid;
    assign o_beat        = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_beat.op   <= s_axis_tuser;
            r_beat.data <= s_axis_tdata;
        end
    end

endmodule

// ===== hdl/fpr_deframer.sv =====
// Frame parser: start hunt, command, length, payload, XOR check, timeout.
module fpr_deframer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fpr_pkg::TICK_W-1:0]    i_cfg_wdata,
    input  logic                          i_take,
    input  fpr_pkg::t_beat                i_beat,
    output logic                          o_evt_valid,
    output fpr_pkg::t_event               o_evt
);
    import fpr_pkg::*;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_CMD     = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4
    } t_phase;

    t_phase            r_phase,   n_phase;
    logic [BYTE_W-1:0] r_cmd,     n_cmd;
    logic [BYTE_W-1:0] r_len,     n_len;
    logic [BYTE_W-1:0] r_count,   n_count;
    logic [BYTE_W-1:0] r_xor,     n_xor;
    logic [BYTE_W-1:0] r_first,   n_first;
    logic [TICK_W-1:0] r_elapsed, n_elapsed;
    logic [TICK_W-1:0] r_timeout;

    logic              late;
    logic [TICK_W-1:0] elapsed_inc;
    logic [BYTE_W-1:0] count_inc;
    logic [BYTE_W-1:0] cmd_dec;

    assign late        = (r_phase != PH_START) && (r_elapsed > r_timeout);
    assign elapsed_inc = (r_elapsed == TICK_MAX) ? r_elapsed : r_elapsed + TICK_W'(1);
    assign count_inc   = r_count + BYTE_W'(1);
    assign cmd_dec     = r_cmd - BYTE_W'(1);

    always_comb begin
        n_phase     = r_phase;
        n_cmd       = r_cmd;
        n_len       = r_len;
        n_count     = r_count;
        n_xor       = r_xor;
        n_first     = r_first;
        n_elapsed   = r_elapsed;
        o_evt_valid = 1'b0;
        o_evt.kind  = cmd_dec[KIND_W-1:0];
        o_evt.arg   = r_first;
        if (i_take) begin
            if (i_beat.op == OP_TICK) begin
                if (r_phase != PH_START) begin
                    n_elapsed = elapsed_inc;
                    if (elapsed_inc > r_timeout) begin
                        n_phase = PH_START;
                    end
                end
            end else if (late) begin
                // abandoned frame; byte is then hunted for a start
                if (i_beat.data == START_BYTE) begin
                    n_phase   = PH_CMD;
                    n_elapsed = '0;
                end else begin
                    n_phase = PH_START;
                end
            end else begin
                unique case (r_phase)
                    PH_START: begin
                        if (i_beat.data == START_BYTE) begin
                            n_phase   = PH_CMD;
                            n_elapsed = '0;
                        end
                    end
                    PH_CMD: begin
                        n_cmd   = i_beat.data;
                        n_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        n_len   = i_beat.data;
                        n_count = '0;
                        n_xor   = r_cmd ^ i_beat.data;
                        n_phase = (i_beat.data == '0) ? PH_CHECK : PH_PAYLOAD;
                    end
                    PH_PAYLOAD: begin
                        if (r_count == '0) begin
                            n_first = i_beat.data;
                        end
                        n_xor   = r_xor ^ i_beat.data;
                        n_count = count_inc;
                        if (count_inc >= r_len) begin
                            n_phase = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        n_phase     = PH_START;
                        o_evt_valid = (i_beat.data == r_xor) && (r_cmd >= CMD_FIRST)
                                      && (r_cmd <= CMD_LAST);
                    end
                    default: begin
                        n_phase = PH_START;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_cmd     <= '0;
            r_len     <= '0;
            r_count   <= '0;
            r_xor     <= '0;
            r_first   <= '0;
            r_elapsed <= '0;
            r_timeout <= TIMEOUT_RESET;
        end else begin
            r_phase   <= n_phase;
            r_cmd     <= n_cmd;
            r_len     <= n_len;
            r_count   <= n_count;
            r_xor     <= n_xor;
            r_first   <= n_first;
            r_elapsed <= n_elapsed;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    a_evt_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt_valid |-> (i_take && r_phase == PH_CHECK))
        else $error("event raised outside checksum phase");

    a_start_clears_elapsed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_beat.op == OP_BYTE && r_phase == PH_START && i_beat.data == START_BYTE)
        |=> (r_phase == PH_CMD && r_elapsed == '0))
        else $error("start byte did not open a frame");

    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_beat.op == OP_TICK && r_phase == PH_START)
        |=> (r_phase == PH_START && $stable(r_elapsed)))
        else $error("tick changed state while hunting for start");

endmodule

// ===== hdl/fpr_out_stage.sv =====
// Result register for decoded events.
module fpr_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  fpr_pkg::t_event i_evt,
    output logic            o_can_load,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [7:0]      m_axis_tdata,  // argument
    output logic [1:0]      m_axis_tuser   // event_kind
);
    import fpr_pkg::*;

    logic   r_valid;
    t_event r_evt;

    assign o_can_load    = !r_valid || m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_evt.arg;
    assign m_axis_tuser  = r_evt.kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
        if (i_load && o_can_load) begin
            r_evt <= i_evt;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_load)
        else $error("event loaded over an unsent result");

endmodule

// ===== hdl/framed_packet_receiver_unit.sv =====
// Top level of the framed packet receiver.
//
//  channel | dir | tdata          | tuser
//  s_axis  | in  | data_byte[7:0] | operation (0 byte, 1 tick)
//  m_axis  | out | argument[7:0]  | event_kind[1:0]
//  cfg     | in  | timeout_ticks[15:0] on i_cfg_wdata when i_cfg_we
//
// One beat per cycle unless a result stalls; a beat sits in the input register,
// then the parser updates state and loads the result register in the same edge.
// m_axis_tvalid rises once the checksum beat's event loads the result register.
// m_axis_tready low holds the result; the input register keeps taking one beat.
// Synchronous active-low reset; timeout_ticks resets to 50.
module framed_packet_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // data_byte
    input  logic        s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // argument
    output logic [1:0]  m_axis_tuser   // event_kind
);
    import fpr_pkg::*;

    logic   in_valid;
    t_beat  in_beat;
    logic   can_load;
    logic   take;
    logic   evt_valid;
    t_event evt;

    assign take = in_valid && can_load;

    fpr_in_stage u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_take        (take),
        .o_valid       (in_valid),
        .o_beat        (in_beat)
    );

    fpr_deframer u_deframer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (take),
        .i_beat      (in_beat),
        .o_evt_valid (evt_valid),
        .o_evt       (evt)
    );

    fpr_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (evt_valid),
        .i_evt         (evt),
        .o_can_load    (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for framed_packet_receiver_unit: frames, checksums, timeouts, stalls.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fpr_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 400;

    typedef enum logic [2:0] {
        ST_HUNT = 3'd0,
        ST_CMD  = 3'd1,
        ST_LEN  = 3'd2,
        ST_BODY = 3'd3,
        ST_SUM  = 3'd4
    } t_rx_state;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [15:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;  // data_byte
    logic        s_axis_tuser  = 1'b0;  // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;  // argument
    logic [1:0]  m_axis_tuser;  // event_kind

    // frame tracker state
    t_rx_state         rx_state;
    logic [BYTE_W-1:0] rx_cmd, rx_len, rx_cnt, rx_xor, rx_first;
    logic [TICK_W-1:0] rx_ticks, tmo_ticks;

    t_event event_q[$];

    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int tick_pct     = 0;
    int beats_sent   = 0;
    int mismatch_cnt = 0;
    int hold_left    = 0;
    bit hold_req     = 1'b0;

    framed_packet_receiver_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic void reset_tracker();
        rx_state  = ST_HUNT;
        rx_cmd    = '0;
        rx_len    = '0;
        rx_cnt    = '0;
        rx_xor    = '0;
        rx_first  = '0;
        rx_ticks  = '0;
        tmo_ticks = TIMEOUT_RESET;
    endfunction

    function automatic void track_beat(input logic op, input logic [BYTE_W-1:0] b);
        t_event ev;
        if (op == OP_TICK) begin
            if (rx_state != ST_HUNT) begin
                if (rx_ticks != TICK_MAX)
                    rx_ticks = rx_ticks + 1'b1;
                if (rx_ticks > tmo_ticks)
                    rx_state = ST_HUNT;
            end
        end else begin
            if (rx_state != ST_HUNT && rx_ticks > tmo_ticks)
                rx_state = ST_HUNT;
            case (rx_state)
                ST_HUNT: begin
                    if (b == START_BYTE) begin
                        rx_state = ST_CMD;
                        rx_ticks = '0;
                    end
                end
                ST_CMD: begin
                    rx_cmd   = b;
                    rx_state = ST_LEN;
                end
                ST_LEN: begin
                    rx_len   = b;
                    rx_cnt   = '0;
                    rx_xor   = rx_cmd ^ b;
                    rx_state = (b == 8'h00) ? ST_SUM : ST_BODY;
                end
                ST_BODY: begin
                    if (rx_cnt == 8'h00)
                        rx_first = b;
                    rx_xor = rx_xor ^ b;
                    rx_cnt = rx_cnt + 1'b1;
                    if (rx_cnt >= rx_len)
                        rx_state = ST_SUM;
                end
                default: begin
                    rx_state = ST_HUNT;
                    if (b == rx_xor && rx_cmd >= CMD_FIRST && rx_cmd <= CMD_LAST) begin
                        ev.kind = KIND_W'(rx_cmd - CMD_FIRST);
                        ev.arg  = rx_first;
                        event_q.push_back(ev);
                    end
                end
            endcase
        end
    endfunction

    function automatic void log_mismatch(input string what, input t_event want,
                                         input t_event got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t tb_top: %s: kind exp %0d got %0d, arg exp %02h got %02h",
                     $realtime, what, want.kind, got.kind, want.arg, got.arg);
    endfunction

    // result side: stall pattern and long hold-off
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_event got;
        t_event want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind = m_axis_tuser;
            got.arg  = m_axis_tdata;
            if (event_q.size() == 0) begin
                want = '0;
                log_mismatch("unexpected event", want, got);
            end else begin
                want = event_q.pop_front();
                if (got.kind !== want.kind || got.arg !== want.arg)
                    log_mismatch("event mismatch", want, got);
            end
        end
    end

    task automatic send_beat(input logic op, input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        beats_sent++;
        track_beat(op, b);
    endtask

    // cut_at < 0 sends the whole frame
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                              input logic [7:0] arg0, input bit bad_sum, input int cut_at);
        logic [7:0] body[$];
        logic [7:0] sum;
        logic [7:0] b;
        body.push_back(START_BYTE);
        body.push_back(cmd);
        body.push_back(len);
        sum = cmd ^ len;
        for (int i = 0; i < int'(len); i++) begin
            b = (i == 0) ? arg0 : 8'($urandom);
            body.push_back(b);
            sum = sum ^ b;
        end
        if (bad_sum)
            sum = sum ^ 8'($urandom_range(255, 1));
        body.push_back(sum);
        for (int i = 0; i < body.size() && i != cut_at; i++) begin
            if ($urandom_range(99) < tick_pct)
                send_beat(OP_TICK, 8'($urandom));
            send_beat(OP_BYTE, body[i]);
        end
    endtask

    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (event_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_timeout(input logic [TICK_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        tmo_ticks = v;
    endtask

    task automatic test_directed_frames();
        tick_pct = 0;
        send_beat(OP_TICK, 8'hFF);
        send_frame(8'h01, 8'h00, 8'h00, 1'b0, -1);  // zero length, preceded only by a tick
        send_frame(CMD_LAST, 8'h01, 8'hFF, 1'b0, -1);
        send_frame(8'h02, 8'h00, 8'h00, 1'b0, -1);  // reuses earlier payload byte
        send_frame(8'h03, 8'h01, START_BYTE, 1'b1, -1);
        send_frame(8'h00, 8'h00, 8'h00, 1'b0, -1);
        drain_block();
    endtask

    task automatic test_frame_timeout();
        tick_pct = 0;
        set_timeout('0);
        send_beat(OP_BYTE, START_BYTE);
        send_beat(OP_TICK, 8'h00);
        send_frame(8'h01, 8'h01, 8'h5A, 1'b0, -1);
        drain_block();
        // largest limit keeps a long frame alive
        set_timeout(TICK_MAX);
        send_frame(8'h02, 8'h01, 8'hA5, 1'b0, 3);
        repeat (200) send_beat(OP_TICK, 8'($urandom));
        send_beat(OP_BYTE, 8'hA5);
        send_beat(OP_BYTE, 8'h02 ^ 8'h01 ^ 8'hA5);
        drain_block();
        // lowered limit hits a frame already in progress
        send_frame(8'h03, 8'h02, 8'h11, 1'b0, 4);
        repeat (5) send_beat(OP_TICK, 8'h00);
        drain_block();
        set_timeout(16'd2);
        send_beat(OP_BYTE, 8'h22);
        send_beat(OP_BYTE, 8'h03 ^ 8'h02 ^ 8'h11 ^ 8'h22);
        send_frame(8'h04, 8'h00, 8'h00, 1'b0, -1);
        drain_block();
        set_timeout(TIMEOUT_RESET);
    endtask

    task automatic test_random_traffic(input int n_beats);
        int stop_at;
        int r;
        logic [7:0] cmd;
        logic [7:0] len;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) begin
            tick_pct = $urandom_range(15);
            if ($urandom_range(99) < 8) begin
                send_beat(1'($urandom), 8'($urandom));
            end else begin
                cmd = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(4, 1));
                r = $urandom_range(99);
                if (r < 85)
                    len = 8'($urandom_range(4));
                else if (r < 98)
                    len = 8'($urandom_range(16));
                else
                    len = 8'($urandom_range(255));
                send_frame(cmd, len, 8'($urandom), ($urandom_range(9) == 0),
                           ($urandom_range(19) == 0) ? int'($urandom_range(len + 3)) : -1);
            end
        end
        drain_block();
    endtask

    task automatic test_output_backpressure();
        tick_pct = 0;
        hold_req = 1'b1;
        repeat (60)
            send_frame(8'($urandom_range(4, 1)), 8'($urandom_range(2)), 8'($urandom),
                       1'b0, -1);
        drain_block();
    endtask

    initial begin
        reset_tracker();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 13;
        dst_idle_pct = 72;
        test_directed_frames();
        test_frame_timeout();
        test_random_traffic(450);

        src_idle_pct = 72;
        dst_idle_pct = 13;
        set_timeout(16'd3);
        test_random_traffic(450);

        src_idle_pct = 0;
        dst_idle_pct = 0;
        set_timeout(16'($urandom));
        test_random_traffic(400);
        test_output_backpressure();

        if (event_q.size() != 0) begin
            mismatch_cnt += event_q.size();
            $display("tb_top: %0d expected events never arrived", event_q.size());
        end
        if (mismatch_cnt == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("tb_top: errors");
        $finish;
    end

endmodule
